[rtl/pfx_pkg.sv]
`timescale 1ns / 1ps
// shared constants, types and codes for the postfix expression evaluator
// no dependencies; used by the interfaces, the controller and the datapath
package pfx_pkg;

	localparam int STACK_DEPTH  = 16;
	localparam int VALUE_WIDTH  = 16;
	localparam int TOKEN_WIDTH  = 8;
	localparam int RESULT_WIDTH = 16;
	localparam int STATUS_WIDTH = 2;

	// stack pointer counts 0..STACK_DEPTH, address selects one entry
	localparam int SP_WIDTH   = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_WIDTH = $clog2(STACK_DEPTH);
	// divider step counter counts VALUE_WIDTH..0
	localparam int CNT_WIDTH  = $clog2(VALUE_WIDTH + 1);

	localparam logic [TOKEN_WIDTH-1:0] CH_ZERO  = 8'h30;
	localparam logic [TOKEN_WIDTH-1:0] CH_NINE  = 8'h39;
	localparam logic [TOKEN_WIDTH-1:0] CH_PLUS  = 8'h2B;
	localparam logic [TOKEN_WIDTH-1:0] CH_MINUS = 8'h2D;
	localparam logic [TOKEN_WIDTH-1:0] CH_STAR  = 8'h2A;
	localparam logic [TOKEN_WIDTH-1:0] CH_SLASH = 8'h2F;

	typedef enum logic [STATUS_WIDTH-1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2,
		ST_DIV_ZERO  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_EXEC,
		S_DIV,
		S_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;      // latch token and last flag
		logic push;        // push digit
		logic flag_over;   // digit on full stack
		logic flag_under;  // operator short of operands
		logic rd_left;     // read left operand from stack memory
		logic alu_fin;     // write + - * result, pop
		logic div_zero;    // divide by zero: push zero, pop, flag
		logic div_load;    // start divider
		logic div_step;    // one divider iteration
		logic emit;        // load result register, clear stack
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_digit;
		logic is_op;
		logic is_div;
		logic sp_full;
		logic sp_lt2;
		logic right_zero;
		logic div_last;
		logic last;
		logic out_free;
	} stat_t;

endpackage

[rtl/pfx_if.sv]
`timescale 1ns / 1ps
// valid/ready channel interfaces for token input and result output
// depends on pfx_pkg for field widths
interface pfx_in_if import pfx_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [TOKEN_WIDTH-1:0] token;
	logic                   last;

	modport source (output valid, token, last, input ready);
	modport sink (input valid, token, last, output ready);
endinterface

interface pfx_out_if import pfx_pkg::*; ();
	logic                           valid;
	logic                           ready;
	logic signed [RESULT_WIDTH-1:0] result_value;
	logic [STATUS_WIDTH-1:0]        status;

	modport source (output valid, result_value, status, input ready);
	modport sink (input valid, result_value, status, output ready);
endinterface

[rtl/pfx_ram.sv]
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
// no dependencies
module pfx_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/pfx_ctrl.sv]
`timescale 1ns / 1ps
// sequencing state machine of the postfix evaluator
// depends on pfx_pkg for state, command and status types
module pfx_ctrl import pfx_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (stat.is_op && !stat.sp_lt2) state_d = S_EXEC;
				else state_d = S_FINISH;
			end
			S_EXEC: begin
				if (stat.is_div && !stat.right_zero) state_d = S_DIV;
				else state_d = S_FINISH;
			end
			S_DIV: begin
				if (stat.div_last) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!stat.last || stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			S_DECODE: begin
				if (stat.is_digit) begin
					cmd.push      = !stat.sp_full;
					cmd.flag_over = stat.sp_full;
				end else if (stat.is_op) begin
					cmd.flag_under = stat.sp_lt2;
					cmd.rd_left    = !stat.sp_lt2;
				end
			end
			S_EXEC: begin
				if (stat.is_div) begin
					cmd.div_zero = stat.right_zero;
					cmd.div_load = !stat.right_zero;
				end else begin
					cmd.alu_fin = 1'b1;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
			end
			S_FINISH: begin
				cmd.emit = stat.last && stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[rtl/pfx_dp.sv]
`timescale 1ns / 1ps
// datapath: token latch, top-of-stack register, stack memory, alu,
// iterative divider, error status and result register; uses pfx_pkg, pfx_ram
module pfx_dp import pfx_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [TOKEN_WIDTH-1:0]         in_token,
	input  logic                           in_last,
	input  cmd_t                           cmd,
	output stat_t                          stat,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [RESULT_WIDTH-1:0] out_value,
	output logic [STATUS_WIDTH-1:0]        out_status
);

	logic [TOKEN_WIDTH-1:0]  tok_q;
	logic                    last_q;
	logic [VALUE_WIDTH-1:0]  top_q;
	logic [SP_WIDTH-1:0]     sp_q;
	status_t                 err_q;
	logic                    out_valid_q;
	logic [RESULT_WIDTH-1:0] out_value_q;
	status_t                 out_status_q;

	logic [VALUE_WIDTH-1:0]  rem_q;
	logic [VALUE_WIDTH-1:0]  quo_q;
	logic [VALUE_WIDTH-1:0]  dvs_q;
	logic                    neg_q;
	logic [CNT_WIDTH-1:0]    cnt_q;

	logic [VALUE_WIDTH-1:0]   left;
	logic [VALUE_WIDTH-1:0]   digit;
	logic [SP_WIDTH-1:0]      sp_m1;
	logic [SP_WIDTH-1:0]      sp_m2;
	logic [2*VALUE_WIDTH-1:0] prod;
	logic [VALUE_WIDTH-1:0]   alu_res;
	logic [VALUE_WIDTH-1:0]   left_mag;
	logic [VALUE_WIDTH-1:0]   right_mag;
	logic [VALUE_WIDTH:0]     rem_sh;
	logic [VALUE_WIDTH:0]     rem_diff;
	logic [VALUE_WIDTH-1:0]   rem_nx;
	logic [VALUE_WIDTH-1:0]   quo_nx;
	logic [VALUE_WIDTH-1:0]   quo_signed;
	status_t                  end_status;

	assign sp_m1 = sp_q - SP_WIDTH'(1);
	assign sp_m2 = sp_q - SP_WIDTH'(2);
	assign digit = VALUE_WIDTH'(tok_q - CH_ZERO);

	pfx_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (cmd.push && (sp_q != '0)),
		.waddr(sp_m1[ADDR_WIDTH-1:0]),
		.wdata(top_q),
		.re   (cmd.rd_left),
		.raddr(sp_m2[ADDR_WIDTH-1:0]),
		.rdata(left)
	);

	// status to controller
	assign stat.is_digit   = (tok_q >= CH_ZERO) && (tok_q <= CH_NINE);
	assign stat.is_op      = (tok_q == CH_PLUS) || (tok_q == CH_MINUS) ||
	                         (tok_q == CH_STAR) || (tok_q == CH_SLASH);
	assign stat.is_div     = (tok_q == CH_SLASH);
	assign stat.sp_full    = (sp_q == SP_WIDTH'(STACK_DEPTH));
	assign stat.sp_lt2     = (sp_q < SP_WIDTH'(2));
	assign stat.right_zero = (top_q == '0);
	assign stat.div_last   = (cnt_q == CNT_WIDTH'(1));
	assign stat.last       = last_q;
	assign stat.out_free   = !out_valid_q || out_ready;

	// add, subtract, multiply; right operand is the cached top
	assign prod = left * top_q;
	always_comb begin
		case (tok_q)
			CH_PLUS:  alu_res = left + top_q;
			CH_MINUS: alu_res = left - top_q;
			CH_STAR:  alu_res = prod[VALUE_WIDTH-1:0];
			default:  alu_res = '0;
		endcase
	end

	// restoring divider on magnitudes, one quotient bit per step
	assign left_mag  = left[VALUE_WIDTH-1] ? (~left + VALUE_WIDTH'(1)) : left;
	assign right_mag = top_q[VALUE_WIDTH-1] ? (~top_q + VALUE_WIDTH'(1)) : top_q;
	assign rem_sh    = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign rem_diff  = rem_sh - {1'b0, dvs_q};
	assign rem_nx    = rem_diff[VALUE_WIDTH] ? rem_sh[VALUE_WIDTH-1:0]
	                                         : rem_diff[VALUE_WIDTH-1:0];
	assign quo_nx    = {quo_q[VALUE_WIDTH-2:0], !rem_diff[VALUE_WIDTH]};
	assign quo_signed = neg_q ? (~quo_nx + VALUE_WIDTH'(1)) : quo_nx;

	// first error sticks; an empty stack at the end counts as underflow
	assign end_status = (err_q != ST_OK) ? err_q :
	                    (sp_q == '0) ? ST_UNDERFLOW : ST_OK;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			tok_q  <= in_token;
			last_q <= in_last;
		end
		if (cmd.push) begin
			top_q <= digit;
		end else if (cmd.alu_fin) begin
			top_q <= alu_res;
		end else if (cmd.div_zero) begin
			top_q <= '0;
		end else if (cmd.div_step && stat.div_last) begin
			top_q <= quo_signed;
		end
		if (cmd.div_load) begin
			rem_q <= '0;
			quo_q <= left_mag;
			dvs_q <= right_mag;
			neg_q <= left[VALUE_WIDTH-1] ^ top_q[VALUE_WIDTH-1];
		end else if (cmd.div_step) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
		if (cmd.emit) begin
			out_value_q  <= (sp_q == '0) ? '0 : RESULT_WIDTH'(top_q);
			out_status_q <= end_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			err_q       <= ST_OK;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				sp_q <= '0;
			end else if (cmd.push) begin
				sp_q <= sp_q + SP_WIDTH'(1);
			end else if (cmd.alu_fin || cmd.div_zero ||
			             (cmd.div_step && stat.div_last)) begin
				sp_q <= sp_m1;
			end

			if (cmd.emit) begin
				err_q <= ST_OK;
			end else if (err_q == ST_OK) begin
				if (cmd.flag_over) err_q <= ST_OVERFLOW;
				else if (cmd.flag_under) err_q <= ST_UNDERFLOW;
				else if (cmd.div_zero) err_q <= ST_DIV_ZERO;
			end

			if (cmd.div_load) begin
				cnt_q <= CNT_WIDTH'(VALUE_WIDTH);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - CNT_WIDTH'(1);
			end

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_status = out_status_q;

	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_WIDTH'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (sp_q == '0) && (err_q == ST_OK) && out_valid_q)
		else $error("end of expression did not clear state");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ST_OK) && !cmd.emit |=> err_q == $past(err_q))
		else $error("held error overwritten");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> cnt_q != '0)
		else $error("divider stepped past its last bit");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_value_q))
		else $error("pending result lost");

endmodule

[rtl/postfix_expression_evaluator_unit.sv]
`timescale 1ns / 1ps
// top level of the postfix expression evaluator: controller plus datapath
// depends on pfx_pkg, pfx_if, pfx_ctrl, pfx_dp, pfx_ram
//
// Evaluates a postfix expression fed one ASCII character per transfer on
// token_ch. Digits push their value, + - * / pop two operands and push the
// result in 16-bit two's complement (wrapping, division truncates toward
// zero), other characters are skipped. The transfer flagged last closes the
// expression: one transfer on result_ch then carries the top value and a
// status (ok, stack underflow, stack overflow, divide by zero; the first
// error of an expression is reported), and the stack is emptied. Tokens are
// handled one at a time, each passing idle, decode and finish; + - * add
// execute (one read of the stack memory for the left operand), and / adds
// execute and a divide state in which the restoring divider resolves one
// quotient bit per cycle over the 16-bit operands. An operator short of
// operands skips execute, a divide by zero skips divide. A result waits in
// an output register, so tokens keep flowing while it is pending; only the
// next last token waits for it to drain. No memory clearing after reset.
module postfix_expression_evaluator_unit import pfx_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	pfx_in_if.sink     token_ch,
	pfx_out_if.source  result_ch
);

	// command and status between sequencer and datapath
	cmd_t  cmd;
	stat_t stat;

	// sequencer: owns input ready, steps through decode, execute,
	// divide and finish as each token needs
	pfx_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(token_ch.valid),
		.in_ready(token_ch.ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// datapath: top-of-stack register, stack memory below it, alu,
	// divider and the result register that drives result_ch
	pfx_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_token  (token_ch.token),
		.in_last   (token_ch.last),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (result_ch.valid),
		.out_ready (result_ch.ready),
		.out_value (result_ch.result_value),
		.out_status(result_ch.status)
	);

endmodule

[sim/postfix_expression_evaluator_unit_test.sv]
`timescale 1ns / 1ps
// self-checking testbench for postfix_expression_evaluator_unit
// depends on pfx_pkg, pfx_if and the evaluator rtl; holds its own stack predictor
module postfix_expression_evaluator_unit_test import pfx_pkg::*; ();

	typedef logic signed [VALUE_WIDTH-1:0] word_t;

	typedef struct {
		logic signed [RESULT_WIDTH-1:0] value;
		status_t                        status;
	} outcome_t;

	// receiver ready patterns
	typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	// characters the block skips, used by name in directed expressions
	localparam logic [TOKEN_WIDTH-1:0] CH_NUL   = 8'h00;
	localparam logic [TOKEN_WIDTH-1:0] CH_SPACE = 8'h20;
	localparam logic [TOKEN_WIDTH-1:0] CH_OPEN  = 8'h28;
	localparam logic [TOKEN_WIDTH-1:0] CH_HIGH  = 8'hFF;

	localparam int RANDOM_ITEMS = 1400;
	localparam int LONG_HOLD    = 300;  // cycles the receiver sits stalled once
	localparam int DRAIN_CYCLES = 60;   // a divide plus output slack

	// shadow of the evaluator: stack, pointer, sticky status, and the
	// queue of results the block still owes
	class postfix_scoreboard;
		word_t    stack_mem[STACK_DEPTH];
		int       depth;
		status_t  sticky;
		outcome_t pending_results[$];
		int       mismatches;
		int       checked;
		int       status_hits[4];

		function new();
			depth = 0;
			sticky = ST_OK;
			mismatches = 0;
			checked = 0;
			foreach (status_hits[i])
				status_hits[i] = 0;
		endfunction

		// only the first error of an expression is kept
		function void raise(status_t s);
			if (sticky == ST_OK)
				sticky = s;
		endfunction

		function word_t evaluate(logic [TOKEN_WIDTH-1:0] op, word_t lhs, word_t rhs);
			word_t q;
			case (op)
				CH_PLUS:  q = lhs + rhs;
				CH_MINUS: q = lhs - rhs;
				CH_STAR:  q = lhs * rhs;
				default: begin
					if (rhs == '0) begin
						raise(ST_DIV_ZERO);
						q = '0;
					end else if (rhs == {VALUE_WIDTH{1'b1}}) begin
						// minus one: plain negate, most negative wraps onto itself
						q = -lhs;
					end else begin
						q = lhs / rhs;
					end
				end
			endcase
			return q;
		endfunction

		function void note_token(logic [TOKEN_WIDTH-1:0] t, logic l);
			word_t    rhs;
			word_t    lhs;
			outcome_t res;
			if (t >= CH_ZERO && t <= CH_NINE) begin
				if (depth >= STACK_DEPTH) begin
					raise(ST_OVERFLOW);
				end else begin
					stack_mem[depth] = {{(VALUE_WIDTH-TOKEN_WIDTH){1'b0}}, t - CH_ZERO};
					depth++;
				end
			end else if (t == CH_PLUS || t == CH_MINUS || t == CH_STAR || t == CH_SLASH) begin
				if (depth < 2) begin
					raise(ST_UNDERFLOW);
				end else begin
					rhs = stack_mem[depth-1];
					lhs = stack_mem[depth-2];
					depth -= 2;
					stack_mem[depth] = evaluate(t, lhs, rhs);
					depth++;
				end
			end
			if (l) begin
				res.value = '0;
				if (depth == 0)
					raise(ST_UNDERFLOW);
				else
					res.value = stack_mem[depth-1][RESULT_WIDTH-1:0];
				res.status = sticky;
				pending_results.push_back(res);
				depth = 0;
				sticky = ST_OK;
			end
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			if (mismatches <= 30)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_result(logic signed [RESULT_WIDTH-1:0] value, logic [STATUS_WIDTH-1:0] status);
			outcome_t want;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result value %0d status %0d", value, status));
			end else begin
				want = pending_results.pop_front();
				checked++;
				status_hits[want.status]++;
				if (value !== want.value)
					report_mismatch($sformatf("result_value %0d, predicted %0d",
						value, want.value));
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, predicted %0d (%s)",
						status, want.status, want.status.name()));
			end
		endtask

		function int pending_count();
			return pending_results.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	pfx_in_if  token_ch();
	pfx_out_if result_ch();

	postfix_expression_evaluator_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.token_ch  (token_ch),
		.result_ch (result_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	postfix_scoreboard sb = new();

	logic [TOKEN_WIDTH-1:0] expr_chars[$];  // expression being assembled
	int burst_left    = 0;   // transfers left before the sender pauses
	int active_sent   = 0;   // digits, operators and closing tokens sent
	int tokens_sent   = 0;
	int exprs_sent    = 0;
	bit long_hold_req = 1'b0;

	function automatic bit is_active(logic [TOKEN_WIDTH-1:0] t);
		return (t >= CH_ZERO && t <= CH_NINE) || t == CH_PLUS || t == CH_MINUS ||
			t == CH_STAR || t == CH_SLASH;
	endfunction

	function automatic logic [TOKEN_WIDTH-1:0] pick_digit();
		return CH_ZERO + TOKEN_WIDTH'($urandom_range(0, 9));
	endfunction

	function automatic logic [TOKEN_WIDTH-1:0] pick_op();
		case ($urandom_range(0, 3))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	// any byte the block skips: parentheses, letters, control codes, high bytes
	function automatic logic [TOKEN_WIDTH-1:0] pick_skipped();
		logic [TOKEN_WIDTH-1:0] c;
		do
			c = TOKEN_WIDTH'($urandom_range(0, 255));
		while (is_active(c));
		return c;
	endfunction

	// one token transfer; between bursts the sender drops valid for a random gap
	task automatic send_token(input logic [TOKEN_WIDTH-1:0] t, input logic l);
		int gap;
		if (burst_left == 0) begin
			token_ch.valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
			// mostly short bursts, now and then a long unbroken run
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		token_ch.valid <= 1'b1;
		token_ch.token <= t;
		token_ch.last  <= l;
		do
			@(posedge clk);
		while (!(token_ch.valid && token_ch.ready));
		sb.note_token(t, l);
		burst_left--;
		tokens_sent++;
		if (is_active(t) || l)
			active_sent++;
	endtask

	// send the assembled expression, last flag on its final character
	task automatic send_expression();
		for (int i = 0; i < expr_chars.size(); i++)
			send_token(expr_chars[i], i == expr_chars.size() - 1);
		expr_chars.delete();
		exprs_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			expr_chars.push_back(s[i]);
		send_expression();
	endtask

	// well-formed postfix with random operands and operators, a skipped
	// character sprinkled in now and then
	task automatic build_well_formed(input int operands);
		int digits_left;
		int level;
		digits_left = operands;
		level = 0;
		while (digits_left > 0 || level > 1) begin
			if (digits_left > 0 && (level < 2 || $urandom_range(0, 1) == 1)) begin
				expr_chars.push_back(pick_digit());
				digits_left--;
				level++;
			end else begin
				expr_chars.push_back(pick_op());
				level--;
			end
			if ($urandom_range(0, 9) == 0)
				expr_chars.push_back(pick_skipped());
		end
	endtask

	// corner expressions that random assembly rarely hits
	task automatic build_corner();
		int n;
		case ($urandom_range(0, 2))
			0: begin
				// push past a full stack, then fold a few values
				n = STACK_DEPTH + $urandom_range(1, 4);
				repeat (n) expr_chars.push_back(pick_digit());
				repeat ($urandom_range(0, 3)) expr_chars.push_back(pick_op());
			end
			1: begin
				// exactly full stack folded back to one value
				repeat (STACK_DEPTH) expr_chars.push_back(pick_digit());
				repeat (STACK_DEPTH - 1) expr_chars.push_back(pick_op());
			end
			default: begin
				// 8^5 wraps to the most negative value, then divide by minus one
				repeat (5) expr_chars.push_back(CH_ZERO + TOKEN_WIDTH'(8));
				repeat (4) expr_chars.push_back(CH_STAR);
				expr_chars.push_back(CH_ZERO);
				expr_chars.push_back(CH_ZERO + TOKEN_WIDTH'(1));
				expr_chars.push_back(CH_MINUS);
				expr_chars.push_back(CH_SLASH);
			end
		endcase
	endtask

	// receiver: checks each result transfer and drives ready by pattern,
	// with one long stall on request so the evaluator backs up
	initial begin
		int       hold_left;
		int       mode_left;
		rx_mode_t mode;
		bit       next_ready;
		hold_left = 0;
		mode_left = 0;
		mode = RX_ALWAYS;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				sb.check_result(result_ch.result_value, result_ch.status);
			if (mode_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(30, 150);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				next_ready = 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
				next_ready = 1'b0;
			end else begin
				case (mode)
					RX_ALWAYS:   next_ready = 1'b1;
					RX_COIN:     next_ready = 1'($urandom_range(0, 1));
					RX_SPARSE:   next_ready = ($urandom_range(0, 3) == 0);
					default:     next_ready = (mode_left % 8) < 3;
				endcase
			end
			result_ch.ready <= next_ready;
		end
	end

	// stimulus: reset, directed expressions, then random ones until done
	initial begin
		int  pick;
		bit  hold_done;
		hold_done = 1'b0;
		arst_n          <= 1'b0;
		token_ch.valid  <= 1'b0;
		token_ch.token  <= CH_NUL;
		token_ch.last   <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all four operators, negative quotient truncated toward zero
		send_text("27-3/");
		send_text("98*1+");
		// operator on an empty stack
		send_text("+");
		// closing on an empty stack with a skipped high byte
		expr_chars.push_back(CH_HIGH);
		send_expression();
		// divide by zero
		send_text("50/");
		// operator short one operand: flagged, stack kept, top returned
		send_text("1+");
		// leftover values are dropped; skipped characters in between
		expr_chars.push_back(CH_NUL);
		expr_chars.push_back(CH_ZERO + TOKEN_WIDTH'(1));
		expr_chars.push_back(CH_OPEN);
		expr_chars.push_back(CH_NINE);
		expr_chars.push_back(CH_SPACE);
		send_expression();
		// first error sticks: underflow, then divide by zero
		send_text("+50/");

		while (active_sent < RANDOM_ITEMS) begin
			// halfway: stall the receiver for a long stretch and keep feeding
			if (!hold_done && active_sent > RANDOM_ITEMS / 2) begin
				hold_done = 1'b1;
				long_hold_req = 1'b1;
				burst_left = 200;
			end
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				build_well_formed(($urandom_range(0, 7) == 0) ? $urandom_range(9, STACK_DEPTH)
					: $urandom_range(1, 8));
				if ($urandom_range(0, 7) == 0)
					expr_chars.push_back(pick_skipped());
			end else if (pick < 82) begin
				// raw bytes, anything goes
				repeat ($urandom_range(1, 6))
					expr_chars.push_back(TOKEN_WIDTH'($urandom_range(0, 255)));
			end else if (pick < 94) begin
				// broken: digits and operators in random order
				repeat ($urandom_range(1, 12))
					expr_chars.push_back(($urandom_range(0, 1) == 1) ? pick_digit() : pick_op());
			end else begin
				build_corner();
			end
			send_expression();
		end
		token_ch.valid <= 1'b0;

		while (sb.pending_count() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d tokens in %0d expressions, %0d results checked",
			tokens_sent, exprs_sent, sb.checked);
		$display("statuses seen: ok %0d, underflow %0d, overflow %0d, divide by zero %0d",
			sb.status_hits[ST_OK], sb.status_hits[ST_UNDERFLOW],
			sb.status_hits[ST_OVERFLOW], sb.status_hits[ST_DIV_ZERO]);
		if (sb.mismatches == 0 && sb.pending_count() == 0) begin
			$display("PASS postfix_expression_evaluator_unit");
		end else begin
			$display("FAIL postfix_expression_evaluator_unit");
		end
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#5ms;
		$display("FAIL postfix_expression_evaluator_unit");
		$finish;
	end

endmodule

[files.f]
rtl/pfx_pkg.sv
rtl/pfx_if.sv
rtl/pfx_ram.sv
rtl/pfx_ctrl.sv
rtl/pfx_dp.sv
rtl/postfix_expression_evaluator_unit.sv
sim/postfix_expression_evaluator_unit_test.sv
